/* hw/rtl/assert_macros.svh */
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// property must hold at every clock edge out of reset
`define ASSERT_CLK(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// condition must never be seen at a clock edge out of reset
`define ASSERT_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLK(name, clk, rst_n, prop)
`define ASSERT_NEVER(name, clk, rst_n, cond)
`endif

`endif

/* hw/rtl/lck_pkg.sv */
package lck_pkg;

  // coordinate width of one grid point field
  localparam int unsigned CRD_W = 7;
  // width of the shared subtract unit
  localparam int unsigned SUB_W = 8;
  // width of the packed key
  localparam int unsigned KEY_W = 33;

  // key packing constants
  localparam logic [8:0]  KEY_OFF_AB = 9'd200;
  localparam logic [8:0]  KEY_MUL_AB = 9'd400;
  localparam logic [15:0] KEY_OFF_C  = 16'd20000;
  localparam logic [15:0] KEY_MUL_C  = 16'd40000;

  // one input word: two grid points
  typedef struct packed {
    logic [CRD_W-1:0] first_x;
    logic [CRD_W-1:0] first_y;
    logic [CRD_W-1:0] second_x;
    logic [CRD_W-1:0] second_y;
  } lck_pts_t;

  // one result word
  typedef struct packed {
    logic [6:0]        coef_a;
    logic signed [7:0] coef_b;
    logic signed [15:0] coef_c;
    logic [KEY_W-1:0]  line_key;
    logic              points_equal;
  } lck_res_t;

endpackage

/* hw/rtl/lck_if.sv */
// input channel: two grid points
interface lck_in_if;
  logic       valid;
  logic       ready;
  logic [6:0] first_x;
  logic [6:0] first_y;
  logic [6:0] second_x;
  logic [6:0] second_y;

  modport source (
    output valid, first_x, first_y, second_x, second_y,
    input  ready
  );
  modport sink (
    input  valid, first_x, first_y, second_x, second_y,
    output ready
  );
endinterface

// output channel: canonical line and key
interface lck_out_if;
  logic               valid;
  logic               ready;
  logic [6:0]         coef_a;
  logic signed [7:0]  coef_b;
  logic signed [15:0] coef_c;
  logic [32:0]        line_key;
  logic               points_equal;

  modport source (
    output valid, coef_a, coef_b, coef_c, line_key, points_equal,
    input  ready
  );
  modport sink (
    input  valid, coef_a, coef_b, coef_c, line_key, points_equal,
    output ready
  );
endinterface

/* hw/rtl/lck_sub.sv */
// shared subtract and compare unit used by both gcd and division steps
module lck_sub import lck_pkg::*; (
  input  logic [SUB_W-1:0] x_i,
  input  logic [SUB_W-1:0] y_i,
  output logic [SUB_W-1:0] diff_o,
  output logic             borrow_o
);

  logic [SUB_W:0] full;

  // borrow set when x is below y
  assign full     = {1'b0, x_i} - {1'b0, y_i};
  assign diff_o   = full[SUB_W-1:0];
  assign borrow_o = full[SUB_W];

endmodule

/* hw/rtl/lck_core.sv */
`include "assert_macros.svh"

// sequencer and datapath: coefficients, binary gcd, restoring division, key
module lck_core import lck_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  lck_pts_t pts_i,
  output logic     ready_o,
  output logic     res_valid_o,
  input  logic     res_ready_i,
  output lck_res_t res_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL0 = 3'd1;
  localparam logic [2:0] S_MUL1 = 3'd2;
  localparam logic [2:0] S_GCD  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_KEY0 = 3'd5;
  localparam logic [2:0] S_KEY1 = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  localparam logic [1:0] OP_A = 2'd0;
  localparam logic [1:0] OP_B = 2'd1;
  localparam logic [1:0] OP_C = 2'd2;

  logic [2:0]  state_q, state_d;
  lck_pts_t    pts_q, pts_d;
  logic [13:0] prod_q, prod_d;
  logic [6:0]  ma_q, ma_d, mb_q, mb_d;
  logic [13:0] mc_q, mc_d;
  logic        sb_q, sb_d, sc_q, sc_d, eq_q, eq_d;
  logic [6:0]  u_q, u_d, v_q, v_d, g_q, g_d;
  logic [2:0]  k_q, k_d;
  logic [1:0]  op_q, op_d;
  logic [13:0] dv_q, dv_d;
  logic [6:0]  rem_q, rem_d;
  logic [13:0] quo_q, quo_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [6:0]  qa_q, qa_d, qb_q, qb_d;
  logic [13:0] qc_q, qc_d;
  logic [17:0] t_q, t_d;
  logic [7:0]  cb_q, cb_d;
  logic [15:0] cc_q, cc_d;
  lck_res_t    res_q, res_d;

  logic [6:0]       mul_x, mul_y;
  logic [13:0]      mul_p;
  logic [7:0]       dx, dy, dx_neg, dy_neg;
  logic [15:0]      c_val, c_neg;
  logic             flip, dx_pos, c_pos;
  logic [6:0]       g_src, g_new;
  logic [SUB_W-1:0] sub_x, sub_y, sub_diff;
  logic             sub_borrow;
  logic [7:0]       rs;
  logic [13:0]      quo_nx;
  logic [7:0]       cb_val;
  logic [15:0]      cc_val, c_off;
  logic [8:0]       a_off, b_off;
  logic [KEY_W-1:0] key_full;

  // one small multiplier, shared over the two cross products
  assign mul_x = (state_q == S_MUL0) ? pts_q.second_y : pts_q.second_x;
  assign mul_y = (state_q == S_MUL0) ? pts_q.first_x  : pts_q.first_y;
  assign mul_p = 14'(mul_x) * 14'(mul_y);

  // direction and constant term, with the sign fix folded in
  assign dx     = {1'b0, pts_q.second_x} - {1'b0, pts_q.first_x};
  assign dy     = {1'b0, pts_q.second_y} - {1'b0, pts_q.first_y};
  assign dx_neg = -dx;
  assign dy_neg = -dy;
  assign c_val  = {2'b00, prod_q} - {2'b00, mul_p};
  assign c_neg  = -c_val;
  assign dx_pos = !dx[7] && (dx != '0);
  assign c_pos  = !c_val[15] && (c_val != '0);
  // a is minus dy: flip when a would be negative, or a zero and b negative
  assign flip   = (!dy[7] && (dy != '0)) || ((dy == '0) && dx[7]);

  // gcd result once one operand has reached zero
  assign g_src = (u_q == '0) ? v_q : u_q;
  assign g_new = g_src << k_q;

  // shared subtract unit operands
  assign rs    = {rem_q, dv_q[13]};
  assign sub_x = (state_q == S_DIV) ? rs : {1'b0, u_q};
  assign sub_y = (state_q == S_DIV) ? {1'b0, g_q} : {1'b0, v_q};

  lck_sub u_sub (
    .x_i     (sub_x),
    .y_i     (sub_y),
    .diff_o  (sub_diff),
    .borrow_o(sub_borrow)
  );

  assign quo_nx = {quo_q[12:0], !sub_borrow};

  // signed coefficients and key offsets
  assign cb_val   = sb_q ? -{1'b0, qb_q} : {1'b0, qb_q};
  assign cc_val   = sc_q ? -{2'b00, qc_q} : {2'b00, qc_q};
  assign a_off    = {2'b00, qa_q} + KEY_OFF_AB;
  assign b_off    = {cb_val[7], cb_val} + KEY_OFF_AB;
  assign c_off    = cc_q + KEY_OFF_C;
  assign key_full = KEY_W'(t_q) * KEY_W'(KEY_MUL_C) + KEY_W'(c_off);

  // sequencer
  always_comb begin
    state_d = state_q;
    pts_d   = pts_q;
    prod_d  = prod_q;
    ma_d    = ma_q;
    mb_d    = mb_q;
    mc_d    = mc_q;
    sb_d    = sb_q;
    sc_d    = sc_q;
    eq_d    = eq_q;
    u_d     = u_q;
    v_d     = v_q;
    g_d     = g_q;
    k_d     = k_q;
    op_d    = op_q;
    dv_d    = dv_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    cnt_d   = cnt_q;
    qa_d    = qa_q;
    qb_d    = qb_q;
    qc_d    = qc_q;
    t_d     = t_q;
    cb_d    = cb_q;
    cc_d    = cc_q;
    res_d   = res_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          pts_d   = pts_i;
          state_d = S_MUL0;
        end
      end
      S_MUL0: begin
        prod_d  = mul_p;
        state_d = S_MUL1;
      end
      S_MUL1: begin
        ma_d    = dy[7] ? dy_neg[6:0] : dy[6:0];
        mb_d    = dx[7] ? dx_neg[6:0] : dx[6:0];
        mc_d    = c_val[15] ? c_neg[13:0] : c_val[13:0];
        sb_d    = flip ? dx_pos : dx[7];
        sc_d    = flip ? c_pos : c_val[15];
        eq_d    = (pts_q.first_x == pts_q.second_x) && (pts_q.first_y == pts_q.second_y);
        u_d     = dy[7] ? dy_neg[6:0] : dy[6:0];
        v_d     = dx[7] ? dx_neg[6:0] : dx[6:0];
        k_d     = '0;
        state_d = S_GCD;
      end
      S_GCD: begin
        if ((u_q == '0) || (v_q == '0)) begin
          g_d = g_new;
          if (g_new == '0) begin
            // coincident points: nothing to divide
            qa_d    = ma_q;
            qb_d    = mb_q;
            qc_d    = mc_q;
            state_d = S_KEY0;
          end else begin
            op_d    = OP_A;
            dv_d    = {ma_q, 7'b0};
            cnt_d   = 4'd7;
            rem_d   = '0;
            quo_d   = '0;
            state_d = S_DIV;
          end
        end else if (!u_q[0] && !v_q[0]) begin
          u_d = u_q >> 1;
          v_d = v_q >> 1;
          k_d = k_q + 3'd1;
        end else if (!u_q[0]) begin
          u_d = u_q >> 1;
        end else if (!v_q[0]) begin
          v_d = v_q >> 1;
        end else if (sub_borrow) begin
          // both odd, u below v: swap so the next step subtracts
          u_d = v_q;
          v_d = u_q;
        end else begin
          u_d = sub_diff[6:0];
        end
      end
      S_DIV: begin
        rem_d = sub_borrow ? rs[6:0] : sub_diff[6:0];
        quo_d = quo_nx;
        dv_d  = dv_q << 1;
        cnt_d = cnt_q - 4'd1;
        if (cnt_q == 4'd1) begin
          rem_d = '0;
          quo_d = '0;
          unique case (op_q)
            OP_A: begin
              qa_d  = quo_nx[6:0];
              op_d  = OP_B;
              dv_d  = {mb_q, 7'b0};
              cnt_d = 4'd7;
            end
            OP_B: begin
              qb_d  = quo_nx[6:0];
              op_d  = OP_C;
              dv_d  = mc_q;
              cnt_d = 4'd14;
            end
            default: begin
              qc_d    = quo_nx;
              state_d = S_KEY0;
            end
          endcase
        end
      end
      S_KEY0: begin
        cb_d    = cb_val;
        cc_d    = cc_val;
        t_d     = 18'(a_off) * 18'(KEY_MUL_AB) + 18'(b_off);
        state_d = S_KEY1;
      end
      S_KEY1: begin
        res_d.coef_a       = qa_q;
        res_d.coef_b       = cb_q;
        res_d.coef_c       = cc_q;
        res_d.line_key     = key_full;
        res_d.points_equal = eq_q;
        state_d            = S_OUT;
      end
      S_OUT: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    pts_q  <= pts_d;
    prod_q <= prod_d;
    ma_q   <= ma_d;
    mb_q   <= mb_d;
    mc_q   <= mc_d;
    sb_q   <= sb_d;
    sc_q   <= sc_d;
    eq_q   <= eq_d;
    u_q    <= u_d;
    v_q    <= v_d;
    g_q    <= g_d;
    k_q    <= k_d;
    op_q   <= op_d;
    dv_q   <= dv_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    cnt_q  <= cnt_d;
    qa_q   <= qa_d;
    qb_q   <= qb_d;
    qc_q   <= qc_d;
    t_q    <= t_d;
    cb_q   <= cb_d;
    cc_q   <= cc_d;
    res_q  <= res_d;
  end

  assign ready_o     = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_OUT);
  assign res_o       = res_q;

  // remainder stays below the divisor throughout a division
  `ASSERT_NEVER(rem_below_divisor, clk_i, rst_ni, (state_q == S_DIV) && (rem_q >= g_q))
  // division only ever runs with a nonzero divisor
  `ASSERT_NEVER(div_nonzero, clk_i, rst_ni, (state_q == S_DIV) && (g_q == '0))
  // coincident points give an all-zero line
  `ASSERT_CLK(equal_gives_zero, clk_i, rst_ni, res_valid_o && res_o.points_equal |-> (res_o.coef_a == '0) && (res_o.coef_b == '0) && (res_o.coef_c == '0))
  // sign fix: with a zero, b is never negative
  `ASSERT_NEVER(sign_canonical, clk_i, rst_ni, res_valid_o && (res_o.coef_a == '0) && res_o.coef_b[7])
  // an offered result waits unchanged for the output register
  `ASSERT_CLK(result_held, clk_i, rst_ni, res_valid_o && !res_ready_i |=> res_valid_o && $stable(res_o))

endmodule

/* hw/rtl/line_canonical_key.sv */
// Canonical line through two grid points.
// Input channel in_i carries one word of two points (first_x/first_y and
// second_x/second_y, 7 bits each); output channel out_o carries the line
// a*x+b*y+c=0 reduced by the gcd of its coefficients, sign-fixed so that a>0
// or a=0 and b>0, the packed key ((a+200)*400+(b+200))*40000+(c+20000), and a
// flag for coincident points (coefficients then zero).
// Both channels use valid/ready; a word moves when both are high.
// One word is worked on at a time, in order: the two cross products on one
// shared multiplier, binary gcd (its steps set by the operand values; the
// subtracting steps use the shared subtractor), restoring division (7+7+14
// quotient bits on the same subtractor; skipped for coincident points), key
// packing and hand-off into the output register.
// in_i.ready rises again once the result has moved into the output register,
// so no new word is taken while the previous one is still in the sequencer.
// A stalled receiver holds the result in the output register; the next word
// is still taken and computed, and waits inside the block until that register
// frees up. Reset empties both the sequencer and the output register.
module line_canonical_key import lck_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  lck_in_if.sink    in_i,
  lck_out_if.source out_o
);

  lck_pts_t pts;
  lck_res_t core_res;
  lck_res_t out_res_q;
  logic     core_ready, core_valid, core_take;
  logic     out_valid_q, out_valid_d;

  // input word into the sequencer
  assign pts.first_x  = in_i.first_x;
  assign pts.first_y  = in_i.first_y;
  assign pts.second_x = in_i.second_x;
  assign pts.second_y = in_i.second_y;
  assign in_i.ready   = core_ready;

  lck_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_i.valid && core_ready),
    .pts_i      (pts),
    .ready_o    (core_ready),
    .res_valid_o(core_valid),
    .res_ready_i(core_take),
    .res_o      (core_res)
  );

  // output register, filled when empty or in the cycle the receiver takes its word
  assign core_take   = !out_valid_q || out_o.ready;
  assign out_valid_d = (core_valid && core_take) ? 1'b1 :
                       (out_o.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (core_valid && core_take) begin
      out_res_q <= core_res;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.coef_a       = out_res_q.coef_a;
  assign out_o.coef_b       = out_res_q.coef_b;
  assign out_o.coef_c       = out_res_q.coef_c;
  assign out_o.line_key     = out_res_q.line_key;
  assign out_o.points_equal = out_res_q.points_equal;

endmodule
